>>> sv/hsih_pkg.sv
package hsih_pkg;

  // Area and bin geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int HUE_BINS   = 10;
  localparam int SAT_BINS   = 10;
  localparam int NUM_BINS   = HUE_BINS * SAT_BINS;
  localparam int HUE_SPAN   = 181;

  // Field widths
  localparam int SIZE_W  = 7;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int CNT_W   = 13;
  localparam int PIX_W   = 8;
  localparam int RPOS_W  = 6;
  localparam int QBIN_W  = 7;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 8;

  // Integral store: one plane of MAX_WIDTH x MAX_HEIGHT entries per bin
  localparam int AREA_SIZE   = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_DEPTH = NUM_BINS * AREA_SIZE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PREV_W      = 2 * CNT_W;

  // Command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_AREA_WIDTH  = 2'd0,
    CFG_AREA_HEIGHT = 2'd1,
    CFG_SAT_THRESH  = 2'd2,
    CFG_VAL_THRESH  = 2'd3
  } hsih_cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RUN,
    ST_PIX_DRAIN,
    ST_Q_PREP,
    ST_Q_READ,
    ST_Q_DRAIN,
    ST_Q_DONE
  } hsih_state_t;

  // Box sum terms of a query
  typedef enum logic [1:0] {
    TERM_SUM  = 2'd0,
    TERM_LEFT = 2'd1,
    TERM_UP   = 2'd2,
    TERM_DIAG = 2'd3
  } hsih_term_t;

  // Clamped configuration seen by the sequencer
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PIX_W-1:0]  sat_th;
    logic [PIX_W-1:0]  val_th;
  } hsih_cfg_t;

  // Bin hit of the current pixel
  typedef struct packed {
    logic             en;
    logic [BIN_W-1:0] bin;
  } hsih_hit_t;

  // Linear store address of an entry
  function automatic logic [ADDR_W-1:0] store_addr(input logic [BIN_W-1:0] bin,
                                                   input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(bin) * ADDR_W'(AREA_SIZE) + ADDR_W'(row) * ADDR_W'(MAX_WIDTH)
        + ADDR_W'(col);
    return a;
  endfunction

endpackage

>>> sv/hsih_ram.sv
module hsih_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hsih_bin_map.sv
module hsih_bin_map (
  input  logic                      clk,
  input  logic [hsih_pkg::PIX_W-1:0] hue,
  input  logic [hsih_pkg::PIX_W-1:0] sat,
  input  logic [hsih_pkg::PIX_W-1:0] val,
  input  hsih_pkg::hsih_cfg_t        cfg,
  output hsih_pkg::hsih_hit_t        hit_r
);

  localparam int HP_W   = hsih_pkg::PIX_W + $clog2(hsih_pkg::HUE_BINS);
  localparam int SP_W   = hsih_pkg::PIX_W + $clog2(hsih_pkg::SAT_BINS);
  localparam int HBIN_W = $clog2(hsih_pkg::HUE_BINS);
  localparam int SBIN_W = $clog2(hsih_pkg::SAT_BINS);
  localparam logic [hsih_pkg::PIX_W-1:0] HUE_MAX = hsih_pkg::PIX_W'(hsih_pkg::HUE_SPAN - 1);

  logic [HP_W-1:0]   hue_prod;
  logic [SP_W-1:0]   sat_prod;
  logic [HBIN_W-1:0] hue_bin;
  logic [SBIN_W-1:0] sat_bin;
  hsih_pkg::hsih_hit_t hit_nxt;

  // hue*HUE_BINS/181 as a count of crossed bin boundaries
  always_comb begin
    hue_prod = HP_W'(hue) * HP_W'(hsih_pkg::HUE_BINS);
    hue_bin  = '0;
    for (int k = 1; k < hsih_pkg::HUE_BINS; k++) begin
      if (hue_prod >= HP_W'(hsih_pkg::HUE_SPAN * k)) begin
        hue_bin = hue_bin + HBIN_W'(1);
      end
    end
  end

  // sat*SAT_BINS/256 is a shift
  assign sat_prod = SP_W'(sat) * SP_W'(hsih_pkg::SAT_BINS);
  assign sat_bin  = sat_prod[SP_W-1:hsih_pkg::PIX_W];

  always_comb begin
    hit_nxt.en  = (hue <= HUE_MAX) && (sat >= cfg.sat_th) && (val >= cfg.val_th);
    hit_nxt.bin = hsih_pkg::BIN_W'(hue_bin) * hsih_pkg::BIN_W'(hsih_pkg::SAT_BINS)
                  + hsih_pkg::BIN_W'(sat_bin);
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

endmodule

>>> sv/hsih_seq.sv
module hsih_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hsih_pkg::hsih_cfg_t         cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [hsih_pkg::PIX_W-1:0]  in_hue,
  input  logic [hsih_pkg::PIX_W-1:0]  in_sat,
  input  logic [hsih_pkg::PIX_W-1:0]  in_val,
  input  logic [hsih_pkg::RPOS_W-1:0] in_rect_x,
  input  logic [hsih_pkg::RPOS_W-1:0] in_rect_y,
  input  logic [hsih_pkg::SIZE_W-1:0] in_rect_w,
  input  logic [hsih_pkg::SIZE_W-1:0] in_rect_h,
  input  logic [hsih_pkg::QBIN_W-1:0] in_bin_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsih_pkg::CNT_W-1:0]  out_bin_count
);

  localparam int SW = hsih_pkg::SIZE_W;
  localparam int CW = hsih_pkg::CNT_W;

  hsih_pkg::hsih_state_t state_r, state_nxt;
  hsih_pkg::hsih_hit_t   hit_r;

  // Latched transaction
  logic                        cmd_r;
  logic [hsih_pkg::PIX_W-1:0]  hue_r, sat_r, val_r;
  logic [hsih_pkg::RPOS_W-1:0] rect_x_r, rect_y_r;
  logic [SW-1:0]               rect_w_r, rect_h_r;
  logic [hsih_pkg::QBIN_W-1:0] qbin_r;

  // Sequencer counters and pipeline stage
  logic [hsih_pkg::BIN_W-1:0] iss_bin_r, s1_bin_r;
  logic                       s1_pix_r, s1_q_r;
  hsih_pkg::hsih_term_t       q_term_r, s1_term_r;
  logic [hsih_pkg::COL_W-1:0] col_r;
  logic [hsih_pkg::ROW_W-1:0] row_r;

  // Query bounds
  logic                       q_ok_r, q_xpos_r, q_ypos_r;
  logic [hsih_pkg::COL_W-1:0] x0_r, x1_r;
  logic [hsih_pkg::ROW_W-1:0] y0_r, y1_r;
  logic [CW-1:0]              acc_r;
  logic                       out_valid_r;
  logic [CW-1:0]              out_count_r;

  // Control strobes
  logic accept, pix_issue, pix_adv, q_prep, q_issue, out_load;

  // Memory ports
  logic [hsih_pkg::ADDR_W-1:0] main_raddr, main_waddr;
  logic [CW-1:0]               main_rdata, main_wdata;
  logic [hsih_pkg::PREV_W-1:0] prev_rdata, prev_wdata;

  // Pixel datapath
  logic [CW-1:0] px_left, px_up, px_diag, px_sum;
  logic          px_inc;

  // Query datapath
  logic [SW-1:0]              qx1_full, qy1_full, qx1_clip, qy1_clip;
  logic                       q_ok;
  logic [CW-1:0]              q_term_val;
  logic                       q_term_sub, q_term_use;
  logic [hsih_pkg::COL_W-1:0] q_col;
  logic [hsih_pkg::ROW_W-1:0] q_row;

  // Position advance
  logic [SW-1:0] col_inc, row_inc;

  hsih_bin_map u_bin_map (
    .clk   (clk),
    .hue   (hue_r),
    .sat   (sat_r),
    .val   (val_r),
    .cfg   (cfg),
    .hit_r (hit_r)
  );

  hsih_ram #(
    .WIDTH (CW),
    .DEPTH (hsih_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s1_pix_r),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  // Per-bin {left, diag} carried from the previous pixel of the row
  hsih_ram #(
    .WIDTH (hsih_pkg::PREV_W),
    .DEPTH (hsih_pkg::NUM_BINS)
  ) u_prev (
    .clk   (clk),
    .we    (s1_pix_r),
    .waddr (s1_bin_r),
    .wdata (prev_wdata),
    .raddr (iss_bin_r),
    .rdata (prev_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsih_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    pix_issue = 1'b0;
    pix_adv   = 1'b0;
    q_prep    = 1'b0;
    q_issue   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      hsih_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = (in_cmd == hsih_pkg::CMD_QUERY) ? hsih_pkg::ST_Q_PREP
                                                      : hsih_pkg::ST_PIX_RUN;
        end
      end
      hsih_pkg::ST_PIX_RUN: begin
        pix_issue = 1'b1;
        if (iss_bin_r == hsih_pkg::BIN_W'(hsih_pkg::NUM_BINS - 1)) begin
          state_nxt = hsih_pkg::ST_PIX_DRAIN;
        end
      end
      hsih_pkg::ST_PIX_DRAIN: begin
        pix_adv   = 1'b1;
        state_nxt = hsih_pkg::ST_IDLE;
      end
      hsih_pkg::ST_Q_PREP: begin
        q_prep    = 1'b1;
        state_nxt = hsih_pkg::ST_Q_READ;
      end
      hsih_pkg::ST_Q_READ: begin
        q_issue = 1'b1;
        if (q_term_r == hsih_pkg::TERM_DIAG) begin
          state_nxt = hsih_pkg::ST_Q_DRAIN;
        end
      end
      hsih_pkg::ST_Q_DRAIN: begin
        state_nxt = hsih_pkg::ST_Q_DONE;
      end
      hsih_pkg::ST_Q_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = hsih_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hsih_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Latch the transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      hue_r    <= in_hue;
      sat_r    <= in_sat;
      val_r    <= in_val;
      rect_x_r <= in_rect_x;
      rect_y_r <= in_rect_y;
      rect_w_r <= in_rect_w;
      rect_h_r <= in_rect_h;
      qbin_r   <= in_bin_index;
    end
  end

  // Issue counters, stage valids, pixel position, output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_bin_r   <= '0;
      q_term_r    <= hsih_pkg::TERM_SUM;
      s1_pix_r    <= 1'b0;
      s1_q_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_pix_r <= pix_issue;
      s1_q_r   <= q_issue;
      if (accept) begin
        iss_bin_r <= '0;
        q_term_r  <= hsih_pkg::TERM_SUM;
      end else begin
        if (pix_issue) begin
          iss_bin_r <= iss_bin_r + hsih_pkg::BIN_W'(1);
        end
        if (q_issue) begin
          q_term_r <= hsih_pkg::hsih_term_t'(q_term_r + 2'd1);
        end
      end
      if (pix_adv) begin
        if (col_inc >= cfg.width) begin
          col_r <= '0;
          row_r <= (row_inc >= cfg.height) ? '0 : row_inc[hsih_pkg::ROW_W-1:0];
        end else begin
          col_r <= col_inc[hsih_pkg::COL_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign col_inc = SW'(col_r) + SW'(1);
  assign row_inc = SW'(row_r) + SW'(1);

  // Stage-one tags
  always_ff @(posedge clk) begin
    s1_bin_r  <= iss_bin_r;
    s1_term_r <= q_term_r;
  end

  // Pixel update: left + up - diag, plus one on the hit bin
  always_comb begin
    px_left = (col_r != '0) ? prev_rdata[hsih_pkg::PREV_W-1:CW] : '0;
    px_diag = (col_r != '0 && row_r != '0) ? prev_rdata[CW-1:0] : '0;
    px_up   = (row_r != '0) ? main_rdata : '0;
    px_inc  = hit_r.en && (hit_r.bin == s1_bin_r);
    px_sum  = px_left + px_up - px_diag + CW'(px_inc);
  end

  assign main_waddr = hsih_pkg::store_addr(s1_bin_r, row_r, col_r);
  assign main_wdata = px_sum;
  assign prev_wdata = {px_sum, px_up};

  // Query clipping
  always_comb begin
    qx1_full = SW'(rect_x_r) + rect_w_r - SW'(1);
    qy1_full = SW'(rect_y_r) + rect_h_r - SW'(1);
    qx1_clip = (qx1_full > cfg.width - SW'(1)) ? cfg.width - SW'(1) : qx1_full;
    qy1_clip = (qy1_full > cfg.height - SW'(1)) ? cfg.height - SW'(1) : qy1_full;
    q_ok     = (qbin_r < hsih_pkg::QBIN_W'(hsih_pkg::NUM_BINS))
               && (SW'(rect_x_r) < cfg.width) && (SW'(rect_y_r) < cfg.height)
               && (rect_w_r != '0) && (rect_h_r != '0);
  end

  always_ff @(posedge clk) begin
    if (q_prep) begin
      q_ok_r   <= q_ok;
      q_xpos_r <= (rect_x_r != '0);
      q_ypos_r <= (rect_y_r != '0);
      x0_r     <= hsih_pkg::COL_W'(rect_x_r);
      y0_r     <= hsih_pkg::ROW_W'(rect_y_r);
      x1_r     <= qx1_clip[hsih_pkg::COL_W-1:0];
      y1_r     <= qy1_clip[hsih_pkg::ROW_W-1:0];
    end
  end

  // Corner of the box for each term
  always_comb begin
    q_col = x1_r;
    q_row = y1_r;
    case (q_term_r)
      hsih_pkg::TERM_SUM: begin
        q_col = x1_r;
        q_row = y1_r;
      end
      hsih_pkg::TERM_LEFT: begin
        q_col = x0_r - hsih_pkg::COL_W'(1);
        q_row = y1_r;
      end
      hsih_pkg::TERM_UP: begin
        q_col = x1_r;
        q_row = y0_r - hsih_pkg::ROW_W'(1);
      end
      hsih_pkg::TERM_DIAG: begin
        q_col = x0_r - hsih_pkg::COL_W'(1);
        q_row = y0_r - hsih_pkg::ROW_W'(1);
      end
      default: begin
        q_col = x1_r;
        q_row = y1_r;
      end
    endcase
  end

  // Shared read port: upper neighbor for pixels, box corners for queries
  assign main_raddr = pix_issue
      ? hsih_pkg::store_addr(iss_bin_r, row_r - hsih_pkg::ROW_W'(1), col_r)
      : hsih_pkg::store_addr(hsih_pkg::BIN_W'(qbin_r), q_row, q_col);

  // Box sum accumulation
  always_comb begin
    q_term_use = 1'b1;
    q_term_sub = 1'b0;
    case (s1_term_r)
      hsih_pkg::TERM_SUM: begin
        q_term_use = 1'b1;
        q_term_sub = 1'b0;
      end
      hsih_pkg::TERM_LEFT: begin
        q_term_use = q_xpos_r;
        q_term_sub = 1'b1;
      end
      hsih_pkg::TERM_UP: begin
        q_term_use = q_ypos_r;
        q_term_sub = 1'b1;
      end
      hsih_pkg::TERM_DIAG: begin
        q_term_use = q_xpos_r && q_ypos_r;
        q_term_sub = 1'b0;
      end
      default: begin
        q_term_use = 1'b0;
        q_term_sub = 1'b0;
      end
    endcase
    q_term_val = q_term_use ? main_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (q_prep) begin
      acc_r <= '0;
    end else if (s1_q_r) begin
      acc_r <= q_term_sub ? acc_r - q_term_val : acc_r + q_term_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= q_ok_r ? acc_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_count_r;

endmodule

>>> sv/hue_sat_integral_histogram.sv
// Pixel transaction: one bin per cycle through the integral store's single read/write port
// pair, all NUM_BINS bins in turn, then a drain state; next item accepted after that.
// Query transaction: a prep state, then four corner reads through the
// same store read port and one shared accumulator; busy until the result slot is free.
// Reset clears the pixel position, the sequencer, the output slot and the registers to
// their defaults; the integral store is not cleared and reads undefined until written.
module hue_sat_integral_histogram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsih_pkg::CIDX_W-1:0] cfg_index,
  input  logic [hsih_pkg::CDAT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [hsih_pkg::PIX_W-1:0]  in_hue,
  input  logic [hsih_pkg::PIX_W-1:0]  in_sat,
  input  logic [hsih_pkg::PIX_W-1:0]  in_val,
  input  logic [hsih_pkg::RPOS_W-1:0] in_rect_x,
  input  logic [hsih_pkg::RPOS_W-1:0] in_rect_y,
  input  logic [hsih_pkg::SIZE_W-1:0] in_rect_w,
  input  logic [hsih_pkg::SIZE_W-1:0] in_rect_h,
  input  logic [hsih_pkg::QBIN_W-1:0] in_bin_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsih_pkg::CNT_W-1:0]  out_bin_count
);

  localparam int SW = hsih_pkg::SIZE_W;

  logic [SW-1:0]              area_width_r, area_height_r;
  logic [hsih_pkg::PIX_W-1:0] sat_th_r, val_th_r;
  hsih_pkg::hsih_cfg_t        cfg;
  hsih_pkg::hsih_cfg_idx_t    cfg_sel;

  // Clamp an area size to 1..limit
  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                              input logic [SW-1:0] limit);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SW'(1);
    end else if (v > limit) begin
      r = limit;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_sel   = hsih_pkg::hsih_cfg_idx_t'(cfg_index);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_width_r  <= SW'(hsih_pkg::MAX_WIDTH);
      area_height_r <= SW'(hsih_pkg::MAX_HEIGHT);
      sat_th_r      <= 8'd26;
      val_th_r      <= 8'd51;
    end else if (cfg_valid) begin
      unique case (cfg_sel)
        hsih_pkg::CFG_AREA_WIDTH:  area_width_r  <= cfg_data[SW-1:0];
        hsih_pkg::CFG_AREA_HEIGHT: area_height_r <= cfg_data[SW-1:0];
        hsih_pkg::CFG_SAT_THRESH:  sat_th_r      <= cfg_data;
        hsih_pkg::CFG_VAL_THRESH:  val_th_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = clamp_size(area_width_r, SW'(hsih_pkg::MAX_WIDTH));
    cfg.height = clamp_size(area_height_r, SW'(hsih_pkg::MAX_HEIGHT));
    cfg.sat_th = sat_th_r;
    cfg.val_th = val_th_r;
  end

  hsih_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_hue        (in_hue),
    .in_sat        (in_sat),
    .in_val        (in_val),
    .in_rect_x     (in_rect_x),
    .in_rect_y     (in_rect_y),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_bin_index  (in_bin_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_count (out_bin_count)
  );

endmodule

>>> bench/bin_count_checker.sv
module bin_count_checker
  import hsih_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_cmd,
  input  logic [PIX_W-1:0]  in_hue,
  input  logic [PIX_W-1:0]  in_sat,
  input  logic [PIX_W-1:0]  in_val,
  input  logic [RPOS_W-1:0] in_rect_x,
  input  logic [RPOS_W-1:0] in_rect_y,
  input  logic [SIZE_W-1:0] in_rect_w,
  input  logic [SIZE_W-1:0] in_rect_h,
  input  logic [QBIN_W-1:0] in_bin_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CNT_W-1:0]  out_bin_count,
  output int                fail_count,
  output int                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAT_SPAN   = 256;
  localparam int RST_AREA   = 64;
  localparam int RST_SAT_TH = 26;
  localparam int RST_VAL_TH = 51;

  // Shadow of the integral store and the raster position
  bit   [CNT_W-1:0]  integral [NUM_BINS][MAX_HEIGHT][MAX_WIDTH];
  int unsigned       pix_col;
  int unsigned       pix_row;

  // Shadow registers
  logic [SIZE_W-1:0] area_width;
  logic [SIZE_W-1:0] area_height;
  logic [PIX_W-1:0]  sat_th;
  logic [PIX_W-1:0]  val_th;

  // Bin counts owed by accepted queries, oldest first
  logic [CNT_W-1:0]  expected_counts [$];
  logic [CNT_W-1:0]  oldest_count;

  initial fail_count = 0;
  initial pending_results = 0;

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // One raster pixel: rebuild every bin's entry at the current position
  task automatic integrate_pixel(logic [PIX_W-1:0] hue, logic [PIX_W-1:0] sat,
                                 logic [PIX_W-1:0] val);
    int unsigned w, h, hit, left, up, diag;
    w = clamp_size(area_width, MAX_WIDTH);
    h = clamp_size(area_height, MAX_HEIGHT);
    hit = NUM_BINS;
    if (hue < HUE_SPAN && sat >= sat_th && val >= val_th)
      hit = (int'(hue) * HUE_BINS / HUE_SPAN) * SAT_BINS + int'(sat) * SAT_BINS / SAT_SPAN;
    for (int b = 0; b < NUM_BINS; b++) begin
      left = (pix_col > 0) ? integral[b][pix_row][pix_col-1] : 0;
      up   = (pix_row > 0) ? integral[b][pix_row-1][pix_col] : 0;
      diag = (pix_col > 0 && pix_row > 0) ? integral[b][pix_row-1][pix_col-1] : 0;
      integral[b][pix_row][pix_col] = CNT_W'(left + up - diag + ((b == hit) ? 1 : 0));
    end
    // raster advance, wrapping at row and frame end
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
      if (pix_row >= h) pix_row = 0;
    end
  endtask

  // Inclusive box sum of one bin over the rectangle clipped to the area
  function automatic logic [CNT_W-1:0] box_count(logic [RPOS_W-1:0] rx, logic [RPOS_W-1:0] ry,
                                                 logic [SIZE_W-1:0] rw, logic [SIZE_W-1:0] rh,
                                                 logic [QBIN_W-1:0] qbin);
    int unsigned w, h, x0, y0, x1, y1, b, total;
    w  = clamp_size(area_width, MAX_WIDTH);
    h  = clamp_size(area_height, MAX_HEIGHT);
    x0 = rx;
    y0 = ry;
    b  = qbin;
    if (b >= NUM_BINS || x0 >= w || y0 >= h || rw == 0 || rh == 0) return '0;
    x1 = x0 + rw - 1;
    y1 = y0 + rh - 1;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    total = integral[b][y1][x1];
    if (x0 > 0) total -= integral[b][y1][x0-1];
    if (y0 > 0) total -= integral[b][y0-1][x1];
    if (x0 > 0 && y0 > 0) total += integral[b][y0-1][x0-1];
    return CNT_W'(total);
  endfunction

  // Watch the three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_col = 0;
      pix_row = 0;
      area_width = SIZE_W'(RST_AREA);
      area_height = SIZE_W'(RST_AREA);
      sat_th = PIX_W'(RST_SAT_TH);
      val_th = PIX_W'(RST_VAL_TH);
      expected_counts.delete();
    end else begin
      // result transaction against the oldest owed count
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          report($sformatf("result with no query waiting, bin_count=%0d", out_bin_count));
        end else begin
          oldest_count = expected_counts.pop_front();
          if (out_bin_count !== oldest_count)
            report($sformatf("bin_count got %0d, expected %0d", out_bin_count, oldest_count));
        end
      end
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (hsih_cfg_idx_t'(cfg_index))
          CFG_AREA_WIDTH:  area_width = cfg_data[SIZE_W-1:0];
          CFG_AREA_HEIGHT: area_height = cfg_data[SIZE_W-1:0];
          CFG_SAT_THRESH:  sat_th = cfg_data;
          CFG_VAL_THRESH:  val_th = cfg_data;
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_PIXEL)
          integrate_pixel(in_hue, in_sat, in_val);
        else
          expected_counts.push_back(box_count(in_rect_x, in_rect_y, in_rect_w, in_rect_h,
                                              in_bin_index));
      end
    end
    pending_results <= expected_counts.size();
  end

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hsih_pkg::*;

  localparam int IDLE_PCT      = 27;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = NUM_BINS + 20;
  localparam int QUIET_LIMIT   = 5000;
  localparam int QUERY_TRIES   = 40;
  localparam int FOCUS_HUE_MAX = 36;
  localparam int FOCUS_SAT_MAX = 51;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDAT_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_cmd = CMD_PIXEL;
  logic [PIX_W-1:0]  in_hue = '0;
  logic [PIX_W-1:0]  in_sat = '0;
  logic [PIX_W-1:0]  in_val = '0;
  logic [RPOS_W-1:0] in_rect_x = '0;
  logic [RPOS_W-1:0] in_rect_y = '0;
  logic [SIZE_W-1:0] in_rect_w = '0;
  logic [SIZE_W-1:0] in_rect_h = '0;
  logic [QBIN_W-1:0] in_bin_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CNT_W-1:0]  out_bin_count;

  int fail_count;
  int pending_results;

  // Stimulus-side view of the area and of which positions hold data
  int unsigned area_w = MAX_WIDTH;
  int unsigned area_h = MAX_HEIGHT;
  int unsigned pix_col = 0;
  int unsigned pix_row = 0;
  bit          written [MAX_HEIGHT][MAX_WIDTH];
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          stall_req = 0;

  hue_sat_integral_histogram dut (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_cmd, .in_hue, .in_sat, .in_val,
    .in_rect_x, .in_rect_y, .in_rect_w, .in_rect_h, .in_bin_index,
    .out_valid, .out_ready, .out_bin_count
  );

  bin_count_checker count_chk (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_cmd, .in_hue, .in_sat, .in_val,
    .in_rect_x, .in_rect_y, .in_rect_w, .in_rect_h, .in_bin_index,
    .out_valid, .out_ready, .out_bin_count,
    .fail_count, .pending_results
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, plus long hold-offs on request
  initial begin
    int hold_left;
    int seen_req;
    hold_left = 0;
    seen_req = 0;
    forever begin
      @(posedge clk);
      if (stall_req != seen_req) begin
        seen_req = stall_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offer one item and hold it until accepted
  task automatic push_item(logic cmd, logic [PIX_W-1:0] hue, logic [PIX_W-1:0] sat,
                           logic [PIX_W-1:0] val, logic [RPOS_W-1:0] rx,
                           logic [RPOS_W-1:0] ry, logic [SIZE_W-1:0] rw,
                           logic [SIZE_W-1:0] rh, logic [QBIN_W-1:0] qbin);
    if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_hue       <= hue;
    in_sat       <= sat;
    in_val       <= val;
    in_rect_x    <= rx;
    in_rect_y    <= ry;
    in_rect_w    <= rw;
    in_rect_h    <= rh;
    in_bin_index <= qbin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Pixel with random query fields; track the raster position
  task automatic send_pixel(logic [PIX_W-1:0] hue, logic [PIX_W-1:0] sat,
                            logic [PIX_W-1:0] val);
    push_item(CMD_PIXEL, hue, sat, val, RPOS_W'($urandom), RPOS_W'($urandom),
              SIZE_W'($urandom), SIZE_W'($urandom), QBIN_W'($urandom));
    written[pix_row][pix_col] = 1'b1;
    pix_col++;
    if (pix_col >= area_w) begin
      pix_col = 0;
      pix_row++;
      if (pix_row >= area_h) pix_row = 0;
    end
  endtask

  task automatic send_query(int unsigned rx, int unsigned ry, int unsigned rw,
                            int unsigned rh, int unsigned qbin);
    push_item(CMD_QUERY, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
              RPOS_W'(rx), RPOS_W'(ry), SIZE_W'(rw), SIZE_W'(rh), QBIN_W'(qbin));
  endtask

  // True when a query would read a position never written since reset
  function automatic bit touches_unwritten(int unsigned x0, int unsigned y0, int unsigned rw,
                                           int unsigned rh, int unsigned qbin);
    int unsigned x1, y1;
    if (qbin >= NUM_BINS || x0 >= area_w || y0 >= area_h || rw == 0 || rh == 0) return 1'b0;
    x1 = (x0 + rw - 1 > area_w - 1) ? area_w - 1 : x0 + rw - 1;
    y1 = (y0 + rh - 1 > area_h - 1) ? area_h - 1 : y0 + rh - 1;
    if (!written[y1][x1]) return 1'b1;
    if (x0 > 0 && !written[y1][x0-1]) return 1'b1;
    if (y0 > 0 && !written[y0-1][x1]) return 1'b1;
    if (x0 > 0 && y0 > 0 && !written[y0-1][x0-1]) return 1'b1;
    return 1'b0;
  endfunction

  // Pixels lean toward a few low hue/sat bins so queries find counts
  task automatic random_pixel();
    int unsigned hue, sat;
    hue = ($urandom_range(99) < 60) ? $urandom_range(FOCUS_HUE_MAX) : $urandom_range(255);
    sat = ($urandom_range(99) < 60) ? $urandom_range(FOCUS_SAT_MAX) : $urandom_range(255);
    send_pixel(PIX_W'(hue), PIX_W'(sat), PIX_W'($urandom_range(255)));
  endtask

  task automatic random_query();
    int unsigned x0, y0, rw, rh, qbin, pick;
    bit ok;
    ok = 1'b0;
    for (int t = 0; t < QUERY_TRIES && !ok; t++) begin
      if ($urandom_range(9) < 8) begin
        x0 = $urandom_range(area_w - 1);
        y0 = $urandom_range(area_h - 1);
        rw = $urandom_range(area_w, 1);
        rh = $urandom_range(area_h, 1);
      end else begin
        x0 = $urandom_range(63);
        y0 = $urandom_range(63);
        rw = $urandom_range(127);
        rh = $urandom_range(127);
      end
      pick = $urandom_range(99);
      if (pick < 60)
        qbin = $urandom_range(1) + SAT_BINS * $urandom_range(1);
      else if (pick < 90)
        qbin = $urandom_range(NUM_BINS - 1);
      else
        qbin = $urandom_range(127);
      ok = !touches_unwritten(x0, y0, rw, rh, qbin);
    end
    // nothing readable found: fall back to an out-of-range bin
    if (!ok) qbin = 127;
    send_query(x0, y0, rw, rh, qbin);
  endtask

  // Drop valid, let owed results drain and the last pixel finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(hsih_cfg_idx_t idx, logic [CDAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_AREA_WIDTH:  area_w = clamp_size(data[SIZE_W-1:0], MAX_WIDTH);
      CFG_AREA_HEIGHT: area_h = clamp_size(data[SIZE_W-1:0], MAX_HEIGHT);
      default: ;
    endcase
  endtask

  // Area changes only at a frame boundary so neighbor reads stay written
  task automatic finish_frame();
    while (pix_col != 0 || pix_row != 0) random_pixel();
  endtask

  task automatic configure(logic [CDAT_W-1:0] w, logic [CDAT_W-1:0] h,
                           logic [CDAT_W-1:0] sat_th, logic [CDAT_W-1:0] val_th);
    finish_frame();
    wait_idle();
    write_reg(CFG_AREA_WIDTH, w);
    write_reg(CFG_AREA_HEIGHT, h);
    write_reg(CFG_SAT_THRESH, sat_th);
    write_reg(CFG_VAL_THRESH, val_th);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly pixels, queries between them
  task automatic run_phase(int n_items, logic [CDAT_W-1:0] w, logic [CDAT_W-1:0] h,
                           logic [CDAT_W-1:0] sat_th, logic [CDAT_W-1:0] val_th);
    configure(w, h, sat_th, val_th);
    repeat (n_items) begin
      if ($urandom_range(99) < 65) random_pixel();
      else random_query();
    end
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one 4x3 frame with threshold and hue edges
    configure(4, 3, 26, 51);
    send_pixel(0, 255, 255);
    send_pixel(180, 26, 51);     // exactly at both thresholds, top hue bin
    send_pixel(181, 255, 255);   // hue past range, not counted
    send_pixel(255, 255, 255);
    send_pixel(20, 25, 200);     // saturation just below
    send_pixel(20, 200, 50);     // value just below
    send_pixel(90, 128, 128);
    send_pixel(0, 255, 255);
    repeat (4) random_pixel();
    send_query(0, 0, 64, 64, 9);
    send_query(0, 0, 4, 3, 91);
    send_query(0, 0, 4, 3, 45);
    send_query(1, 1, 2, 2, 9);
    send_query(3, 2, 1, 1, 9);
    send_query(3, 0, 127, 127, 0);
    send_query(4, 0, 1, 1, 9);   // left edge outside area
    send_query(0, 3, 1, 1, 9);   // top edge outside area
    send_query(63, 63, 1, 1, 9);
    send_query(0, 0, 0, 3, 9);   // zero width
    send_query(0, 0, 4, 0, 9);   // zero height
    send_query(0, 0, 4, 3, 100); // bin out of range
    send_query(0, 0, 4, 3, 127);

    // width shrunk mid-frame: current column already past the new width
    repeat (6) random_pixel();
    wait_idle();
    write_reg(CFG_AREA_WIDTH, 2);
    cfg_valid <= 1'b0;
    finish_frame();
    repeat (4) random_query();

    // ordinary area, then a receiver hold-off that backs up the input
    run_phase(70, 8, 8, 26, 51);
    finish_frame();
    tx_idle_en = 1'b0;
    stall_req++;
    repeat (8) random_query();
    tx_idle_en = 1'b1;
    wait_idle();

    // extremes: clamped sizes and threshold limits
    run_phase(70, 0, 64, 0, 0);
    run_phase(70, 200, 2, 255, 255);

    // stretch with no idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(60, 127, 1, 128, 10);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    run_phase(70, 5, 7, CDAT_W'($urandom_range(255)), CDAT_W'($urandom_range(120)));
    run_phase(60, 3, 3, 13, 200);

    wait_idle();
    if (fail_count == 0 && pending_results == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
